// ----- src/krt_pkg.sv -----
// ----------------------------------------------------------------------------
// krt_pkg
// Record layout, action, filter and status codes for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int ID_W    = 27;
    localparam int ROOMS_W = 8;
    localparam int AREA_W  = 17;
    localparam int DATE_W  = 20;
    localparam int PHONE_W = 24;
    localparam int IDX_W   = 5;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [ROOMS_W-1:0] rooms;
        logic [AREA_W-1:0]  tot;
        logic [AREA_W-1:0]  liv;
        logic [DATE_W-1:0]  date;
        logic [AREA_W-1:0]  price;
        logic [PHONE_W-1:0] phone;
    } t_rec;

    localparam logic [2:0] ACT_APPEND  = 3'd0;
    localparam logic [2:0] ACT_REPLACE = 3'd1;
    localparam logic [2:0] ACT_DELETE  = 3'd2;
    localparam logic [2:0] ACT_DEDUPE  = 3'd3;
    localparam logic [2:0] ACT_LOOKUP  = 3'd4;
    localparam logic [2:0] ACT_FILTER  = 3'd5;

    localparam logic [2:0] FK_TOT_EQ = 3'd0;
    localparam logic [2:0] FK_TOT_LT = 3'd1;
    localparam logic [2:0] FK_TOT_GT = 3'd2;
    localparam logic [2:0] FK_LIV_EQ = 3'd3;
    localparam logic [2:0] FK_LIV_LT = 3'd4;
    localparam logic [2:0] FK_LIV_GT = 3'd5;
    localparam logic [2:0] FK_DATE   = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD_IDX = 2'd3;

    localparam int MAX_OUT = 32;

endpackage

// ----- src/keyed_record_table.sv -----
// ----------------------------------------------------------------------------
// keyed_record_table
// Table of up to DEPTH realty records held in one synchronous memory.
//
// Usage: drive an action and its record fields with start while busy is
// low; the beat is taken at that edge. Results come back on the o_ ports,
// each marked by o_valid for a single cycle, with o_last on the final one;
// the receiver cannot hold them off. Append, replace, unused actions and
// dedupe of an empty table answer in the cycle after the accepting edge.
// Delete shifts the tail one entry per cycle. Dedupe compares each entry
// with the kept ones at one read per cycle. Filter scans one entry per
// cycle and holds each match until the next one or the end of the scan,
// so the final one carries o_last. Lookup runs an insertion sort, then a
// binary search. All rates are set by the single read port of the record
// memory. busy drops in the cycle that shows the last result of a beat.
// Reset empties the table (the count clears); memory contents stay
// undefined and are never read before being written.
// ----------------------------------------------------------------------------
module keyed_record_table import krt_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_action,
    input  logic [IDX_W-1:0]   i_rec_index,
    input  logic [ID_W-1:0]    i_rec_id,
    input  logic [ROOMS_W-1:0] i_rec_rooms,
    input  logic [AREA_W-1:0]  i_rec_total_area,
    input  logic [AREA_W-1:0]  i_rec_living_area,
    input  logic [DATE_W-1:0]  i_rec_build_date,
    input  logic [AREA_W-1:0]  i_rec_price,
    input  logic [PHONE_W-1:0] i_rec_phone,
    input  logic [2:0]         i_filter_kind,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [IDX_W-1:0]   o_out_index,
    output logic [ID_W-1:0]    o_out_id,
    output logic [ROOMS_W-1:0] o_out_rooms,
    output logic [AREA_W-1:0]  o_out_total_area,
    output logic [AREA_W-1:0]  o_out_living_area,
    output logic [DATE_W-1:0]  o_out_build_date,
    output logic [AREA_W-1:0]  o_out_price,
    output logic [PHONE_W-1:0] o_out_phone,
    output logic               o_last,
    output logic [5:0]         o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DEL_R  = 13'b0000000000010,
        S_DEL_W  = 13'b0000000000100,
        S_DD_RI  = 13'b0000000001000,
        S_DD_RJ  = 13'b0000000010000,
        S_DD_CK  = 13'b0000000100000,
        S_SO_RK  = 13'b0000001000000,
        S_SO_RP  = 13'b0000010000000,
        S_SO_CK  = 13'b0000100000000,
        S_SO_WK  = 13'b0001000000000,
        S_BS_RD  = 13'b0010000000000,
        S_BS_CK  = 13'b0100000000000,
        S_FI_CK  = 13'b1000000000000
    } t_state;

    localparam t_state S_FI_END = t_state'(13'b0000000000000);

    t_rec mem [DEPTH];

    t_state         r_state, n_state;
    logic [CW-1:0]  r_held, n_held;
    logic [CW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_j, n_j;
    logic [CW-1:0]  r_n, n_n;
    logic [CW-1:0]  r_lo, n_lo;
    logic [CW-1:0]  r_hi, n_hi;
    logic [5:0]     r_cnt, n_cnt;
    logic           r_hit, n_hit;
    logic [2:0]     r_kind;
    t_rec           r_in;
    t_rec           r_key, n_key;
    t_rec           r_gone, n_gone;
    t_rec           r_rd;

    logic           rd_en, wr_en;
    logic [AW-1:0]  rd_addr, wr_addr;
    t_rec           wr_data;

    logic           r_ov, n_ov;
    logic [1:0]     r_ost, n_ost;
    logic [IDX_W-1:0] r_oidx, n_oidx;
    t_rec           r_orec, n_orec;
    logic           r_olast, n_olast;

    logic           fhit;
    logic [CW-1:0]  mid;
    logic           accept;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_comb begin
        case (r_kind)
            FK_TOT_EQ: fhit = (r_rd.tot == r_in.tot);
            FK_TOT_LT: fhit = (r_rd.tot <  r_in.tot);
            FK_TOT_GT: fhit = (r_rd.tot >  r_in.tot);
            FK_LIV_EQ: fhit = (r_rd.liv == r_in.liv);
            FK_LIV_LT: fhit = (r_rd.liv <  r_in.liv);
            FK_LIV_GT: fhit = (r_rd.liv >  r_in.liv);
            FK_DATE:   fhit = (r_rd.date == r_in.date);
            default:   fhit = 1'b0;
        endcase
    end

    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        t_rec in_rec;
        in_rec = '{i_rec_id, i_rec_rooms, i_rec_total_area, i_rec_living_area,
                   i_rec_build_date, i_rec_price, i_rec_phone};
        n_state = r_state;
        n_held  = r_held;
        n_i     = r_i;
        n_j     = r_j;
        n_n     = r_n;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_cnt   = r_cnt;
        n_hit   = r_hit;
        n_key   = r_key;
        n_gone  = r_gone;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_rd;
        n_ov    = 1'b0;
        n_ost   = ST_OK;
        n_oidx  = '0;
        n_orec  = '0;
        n_olast = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_APPEND: begin
                            n_ov = 1'b1;
                            if (r_held >= CW'(DEPTH)) begin
                                n_ost = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_held[AW-1:0];
                                wr_data = in_rec;
                                n_held  = r_held + 1'b1;
                                n_oidx  = IDX_W'(r_held);
                                n_orec  = in_rec;
                            end
                        end
                        ACT_REPLACE: begin
                            n_ov   = 1'b1;
                            n_oidx = i_rec_index;
                            if (CW'(i_rec_index) >= r_held) begin
                                n_ost = ST_BAD_IDX;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(i_rec_index);
                                wr_data = in_rec;
                                n_orec  = in_rec;
                            end
                        end
                        ACT_DELETE: begin
                            if (CW'(i_rec_index) >= r_held) begin
                                n_ov   = 1'b1;
                                n_oidx = i_rec_index;
                                n_ost  = ST_BAD_IDX;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(i_rec_index);
                                n_i     = CW'(i_rec_index);
                                // hold the original index in r_lo through the shift
                                n_lo    = CW'(i_rec_index);
                                n_state = S_DEL_R;
                            end
                        end
                        ACT_DEDUPE: begin
                            if (r_held == '0) begin
                                n_ov = 1'b1;
                            end else begin
                                n_i     = '0;
                                n_n     = '0;
                                n_state = S_DD_RI;
                            end
                        end
                        ACT_LOOKUP: begin
                            n_i     = CW'(1);
                            n_state = S_SO_RK;
                        end
                        ACT_FILTER: begin
                            n_i   = '0;
                            n_cnt = '0;
                            n_hit = 1'b0;
                            if (r_held == '0) begin
                                n_ov  = 1'b1;
                                n_ost = ST_MISS;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_state = S_FI_CK;
                            end
                        end
                        default: n_ov = 1'b1;
                    endcase
                end
            end

            // delete: r_rd holds entry r_i; capture removed record, then shift
            S_DEL_R: begin
                n_gone = r_rd;
                if (r_i + 1'b1 < r_held) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_i + 1'b1);
                    n_state = S_DEL_W;
                end else begin
                    n_held  = r_held - 1'b1;
                    n_ov    = 1'b1;
                    n_oidx  = IDX_W'(r_i);
                    n_orec  = r_rd;
                    n_state = S_IDLE;
                end
            end
            S_DEL_W: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_i);
                wr_data = r_rd;
                n_i     = r_i + 1'b1;
                if (r_i + 2'd2 < r_held) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_i + 2'd2);
                end else begin
                    n_held  = r_held - 1'b1;
                    n_ov    = 1'b1;
                    n_oidx  = IDX_W'(r_lo);
                    n_orec  = r_gone;
                    n_state = S_IDLE;
                end
            end

            // dedupe: key = entry i, compare against kept entries 0..n-1
            S_DD_RI: begin
                if (r_i >= r_held) begin
                    n_held  = r_n;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_i);
                    n_j     = '0;
                    n_state = S_DD_RJ;
                end
            end
            S_DD_RJ: begin
                if (r_j == '0) begin
                    n_key = r_rd;
                end
                if (r_j < r_n) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_j);
                    n_state = S_DD_CK;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_n);
                    wr_data = (r_j == '0) ? r_rd : r_key;
                    n_n     = r_n + 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = S_DD_RI;
                end
            end
            S_DD_CK: begin
                if (r_rd.id == r_key.id) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_DD_RI;
                end else begin
                    n_j = r_j + 1'b1;
                    if (r_j + 1'b1 < r_n) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(r_j + 1'b1);
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(r_n);
                        wr_data = r_key;
                        n_n     = r_n + 1'b1;
                        n_i     = r_i + 1'b1;
                        n_state = S_DD_RI;
                    end
                end
            end

            // insertion sort: key = entry i, j walks down
            S_SO_RK: begin
                if (r_i >= r_held) begin
                    n_lo    = '0;
                    n_hi    = r_held;
                    n_state = S_BS_RD;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_i);
                    n_j     = r_i;
                    n_state = S_SO_RP;
                end
            end
            S_SO_RP: begin
                if (r_j == r_i) begin
                    n_key = r_rd;
                end
                rd_en   = 1'b1;
                rd_addr = AW'(r_j - 1'b1);
                n_state = S_SO_CK;
            end
            S_SO_CK: begin
                if (r_rd.id > r_key.id) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_j);
                    wr_data = r_rd;
                    n_j     = r_j - 1'b1;
                    if (r_j - 1'b1 == '0) begin
                        n_state = S_SO_WK;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(r_j - 2'd2);
                    end
                end else begin
                    if (r_j != r_i) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(r_j);
                        wr_data = r_key;
                    end
                    n_i     = r_i + 1'b1;
                    n_state = S_SO_RK;
                end
            end
            S_SO_WK: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = r_key;
                n_i     = r_i + 1'b1;
                n_state = S_SO_RK;
            end

            // binary search for the first id not below the key
            S_BS_RD: begin
                if (r_lo < r_hi) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(mid);
                    n_state = S_BS_CK;
                end else if (r_lo < r_held) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_lo);
                    n_hi    = '0;
                    n_state = S_BS_CK;
                end else begin
                    n_ov    = 1'b1;
                    n_ost   = ST_MISS;
                    n_state = S_IDLE;
                end
            end
            S_BS_CK: begin
                if (r_lo < r_hi) begin
                    if (r_rd.id < r_in.id) begin
                        n_lo = mid + 1'b1;
                    end else begin
                        n_hi = mid;
                    end
                    n_state = S_BS_RD;
                end else begin
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                    if (r_rd.id == r_in.id) begin
                        n_oidx = IDX_W'(r_lo);
                        n_orec = r_rd;
                    end else begin
                        n_ost = ST_MISS;
                    end
                end
            end

            // filter: r_rd holds entry r_i; hold each match until the next one is
            // taken so the final one carries last
            S_FI_CK: begin
                logic more;
                logic take;
                more = (r_i + 1'b1 < r_held);
                take = fhit && (r_cnt < 6'(MAX_OUT));
                if (take) begin
                    n_key = r_rd;
                    n_j   = r_i;
                    n_hit = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (r_hit) begin
                        n_ov    = 1'b1;
                        n_oidx  = IDX_W'(r_j);
                        n_orec  = r_key;
                        n_olast = 1'b0;
                    end
                end
                if (more && !(take && r_cnt + 1'b1 >= 6'(MAX_OUT))) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_i + 1'b1);
                    n_i     = r_i + 1'b1;
                end else begin
                    n_state = S_FI_END;
                end
            end
            S_FI_END: begin
                n_ov    = 1'b1;
                n_state = S_IDLE;
                if (r_hit) begin
                    n_oidx = IDX_W'(r_j);
                    n_orec = r_key;
                end else begin
                    n_ost = ST_MISS;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_n     <= n_n;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_cnt   <= n_cnt;
        r_hit   <= n_hit;
        r_key   <= n_key;
        r_gone  <= n_gone;
        r_ost   <= n_ost;
        r_oidx  <= n_oidx;
        r_orec  <= n_orec;
        r_olast <= n_olast;
        if (accept) begin
            r_kind <= i_filter_kind;
            r_in   <= '{i_rec_id, i_rec_rooms, i_rec_total_area, i_rec_living_area,
                        i_rec_build_date, i_rec_price, i_rec_phone};
        end
    end

    assign o_valid           = r_ov;
    assign o_status          = r_ost;
    assign o_out_index       = r_oidx;
    assign o_out_id          = r_orec.id;
    assign o_out_rooms       = r_orec.rooms;
    assign o_out_total_area  = r_orec.tot;
    assign o_out_living_area = r_orec.liv;
    assign o_out_build_date  = r_orec.date;
    assign o_out_price       = r_orec.price;
    assign o_out_phone       = r_orec.phone;
    assign o_last            = r_olast;
    assign o_entry_count     = 6'(r_held);

endmodule

// ----- sim/krt_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// krt_checker
// Watches the command and result channels of keyed_record_table. It keeps a
// shadow copy of the record table, works out the results of every accepted
// command and compares each result beat, field by field, with the oldest
// prediction that is still waiting.
// ----------------------------------------------------------------------------
module krt_checker import krt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         i_action,
    input  logic [IDX_W-1:0]   i_rec_index,
    input  t_rec               i_rec,
    input  logic [2:0]         i_filter_kind,
    input  logic               i_valid,
    input  logic [1:0]         i_status,
    input  logic [IDX_W-1:0]   i_out_index,
    input  t_rec               i_out_rec,
    input  logic               i_last,
    input  logic [5:0]         i_entry_count,
    output int                 o_failures,
    output int                 o_pending,
    output int                 o_results
);

    localparam int TABLE_DEPTH = 32;

    typedef struct {
        logic [1:0]       status;
        logic [IDX_W-1:0] index;
        t_rec             rec;
        logic             last;
        logic [5:0]       count;
    } t_beat;

    t_rec  shadow [TABLE_DEPTH];
    int    held;
    t_beat awaited [$];

    function automatic void push_beat(logic [1:0] st, int idx, t_rec r, logic lst);
        t_beat b;
        b.status = st;
        b.index  = idx[IDX_W-1:0];
        b.rec    = r;
        b.last   = lst;
        b.count  = held[5:0];
        awaited  = {awaited, b};
    endfunction

    function automatic logic filter_hit(t_rec e, logic [2:0] kind, t_rec q);
        case (kind)
            FK_TOT_EQ: return e.tot == q.tot;
            FK_TOT_LT: return e.tot < q.tot;
            FK_TOT_GT: return e.tot > q.tot;
            FK_LIV_EQ: return e.liv == q.liv;
            FK_LIV_LT: return e.liv < q.liv;
            FK_LIV_GT: return e.liv > q.liv;
            FK_DATE:   return e.date == q.date;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic void predict_action(logic [2:0] act, int idx, t_rec r,
                                           logic [2:0] kind);
        t_rec zero_rec;
        t_rec moved;
        int   n;
        int   j;
        int   found;
        logic dup;
        zero_rec = '0;
        case (act)
            ACT_APPEND: begin
                if (held >= TABLE_DEPTH) begin
                    push_beat(ST_FULL, 0, zero_rec, 1'b1);
                end else begin
                    shadow[held] = r;
                    held++;
                    push_beat(ST_OK, held - 1, r, 1'b1);
                end
            end
            ACT_REPLACE: begin
                if (idx >= held) begin
                    push_beat(ST_BAD_IDX, idx, zero_rec, 1'b1);
                end else begin
                    shadow[idx] = r;
                    push_beat(ST_OK, idx, r, 1'b1);
                end
            end
            ACT_DELETE: begin
                if (idx >= held) begin
                    push_beat(ST_BAD_IDX, idx, zero_rec, 1'b1);
                end else begin
                    moved = shadow[idx];
                    for (int i = idx; i + 1 < held; i++) shadow[i] = shadow[i+1];
                    held--;
                    push_beat(ST_OK, idx, moved, 1'b1);
                end
            end
            ACT_DEDUPE: begin
                n = 0;
                for (int i = 0; i < held; i++) begin
                    dup = 1'b0;
                    for (int k = 0; k < n; k++)
                        if (shadow[k].id == shadow[i].id) dup = 1'b1;
                    if (!dup) begin
                        shadow[n] = shadow[i];
                        n++;
                    end
                end
                held = n;
                push_beat(ST_OK, 0, zero_rec, 1'b1);
            end
            ACT_LOOKUP: begin
                for (int i = 1; i < held; i++) begin
                    moved = shadow[i];
                    j = i;
                    while (j > 0 && shadow[j-1].id > moved.id) begin
                        shadow[j] = shadow[j-1];
                        j--;
                    end
                    shadow[j] = moved;
                end
                found = -1;
                for (int i = held - 1; i >= 0; i--)
                    if (shadow[i].id == r.id) found = i;
                if (found >= 0) push_beat(ST_OK, found, shadow[found], 1'b1);
                else push_beat(ST_MISS, 0, zero_rec, 1'b1);
            end
            ACT_FILTER: begin
                n = 0;
                for (int i = 0; i < held && n < MAX_OUT; i++) begin
                    if (filter_hit(shadow[i], kind, r)) begin
                        push_beat(ST_OK, i, shadow[i], 1'b0);
                        n++;
                    end
                end
                if (n == 0) push_beat(ST_MISS, 0, zero_rec, 1'b1);
                else awaited[$].last = 1'b1;
            end
            default: push_beat(ST_OK, 0, zero_rec, 1'b1);
        endcase
    endfunction

    initial begin
        held       = 0;
        o_failures = 0;
        o_results  = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        t_beat b;
        if (!i_rst_n) begin
            held = 0;
            awaited.delete();
        end else begin
            if (i_valid) begin
                o_results <= o_results + 1;
                if (awaited.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_failures <= o_failures + 1;
                end else begin
                    b = awaited.pop_front();
                    if ({i_status, i_out_index, i_out_rec, i_last, i_entry_count} !==
                        {b.status, b.index, b.rec, b.last, b.count}) begin
                        o_failures <= o_failures + 1;
                        if (i_status !== b.status)
                            $error("status: expected %0d, got %0d", b.status, i_status);
                        if (i_out_index !== b.index)
                            $error("out_index: expected %0d, got %0d", b.index, i_out_index);
                        if (i_out_rec.id !== b.rec.id)
                            $error("out_id: expected %0d, got %0d", b.rec.id, i_out_rec.id);
                        if (i_out_rec.rooms !== b.rec.rooms)
                            $error("out_rooms: expected %0d, got %0d",
                                   b.rec.rooms, i_out_rec.rooms);
                        if (i_out_rec.tot !== b.rec.tot)
                            $error("out_total_area: expected %0d, got %0d",
                                   b.rec.tot, i_out_rec.tot);
                        if (i_out_rec.liv !== b.rec.liv)
                            $error("out_living_area: expected %0d, got %0d",
                                   b.rec.liv, i_out_rec.liv);
                        if (i_out_rec.date !== b.rec.date)
                            $error("out_build_date: expected %0d, got %0d",
                                   b.rec.date, i_out_rec.date);
                        if (i_out_rec.price !== b.rec.price)
                            $error("out_price: expected %0d, got %0d",
                                   b.rec.price, i_out_rec.price);
                        if (i_out_rec.phone !== b.rec.phone)
                            $error("out_phone: expected %0d, got %0d",
                                   b.rec.phone, i_out_rec.phone);
                        if (i_last !== b.last)
                            $error("last: expected %0d, got %0d", b.last, i_last);
                        if (i_entry_count !== b.count)
                            $error("entry_count: expected %0d, got %0d",
                                   b.count, i_entry_count);
                    end
                end
            end
            if (start && !busy)
                predict_action(i_action, i_rec_index, i_rec, i_filter_kind);
        end
        o_pending <= awaited.size();
    end

endmodule

// ----- sim/keyed_record_table_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_record_table_test
// Drives keyed_record_table with a short directed sequence covering empty
// and out-of-range cases, every action and filter kind, then with random
// commands biased to fill and drain the table with colliding ids and areas.
// A checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module keyed_record_table_test;
    import krt_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         action;
    logic [IDX_W-1:0]   rec_index;
    t_rec               rec;
    logic [2:0]         filter_kind;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [IDX_W-1:0]   o_out_index;
    t_rec               out_rec;
    logic               o_last;
    logic [5:0]         o_entry_count;
    int                 failures;
    int                 pending;
    int                 results;
    int                 sent;
    int                 gap_pct;

    keyed_record_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(action), .i_rec_index(rec_index),
        .i_rec_id(rec.id), .i_rec_rooms(rec.rooms),
        .i_rec_total_area(rec.tot), .i_rec_living_area(rec.liv),
        .i_rec_build_date(rec.date), .i_rec_price(rec.price),
        .i_rec_phone(rec.phone), .i_filter_kind(filter_kind),
        .o_valid(o_valid), .o_status(o_status), .o_out_index(o_out_index),
        .o_out_id(out_rec.id), .o_out_rooms(out_rec.rooms),
        .o_out_total_area(out_rec.tot), .o_out_living_area(out_rec.liv),
        .o_out_build_date(out_rec.date), .o_out_price(out_rec.price),
        .o_out_phone(out_rec.phone), .o_last(o_last),
        .o_entry_count(o_entry_count)
    );

    krt_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(action), .i_rec_index(rec_index), .i_rec(rec),
        .i_filter_kind(filter_kind), .i_valid(o_valid), .i_status(o_status),
        .i_out_index(o_out_index), .i_out_rec(out_rec), .i_last(o_last),
        .i_entry_count(o_entry_count), .o_failures(failures),
        .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_rec random_record();
        t_rec r;
        r.id    = ($urandom_range(0, 1)) ? ID_W'($urandom_range(0, 15)) :
                  ($urandom_range(0, 9) == 0) ? '1 : ID_W'($urandom);
        r.rooms = ROOMS_W'($urandom);
        r.tot   = ($urandom_range(0, 1)) ? AREA_W'($urandom_range(0, 3) * 256) :
                  AREA_W'($urandom);
        r.liv   = ($urandom_range(0, 1)) ? AREA_W'($urandom_range(0, 3) * 256) :
                  AREA_W'($urandom);
        r.date  = ($urandom_range(0, 1)) ? DATE_W'($urandom_range(0, 3)) :
                  DATE_W'($urandom);
        r.price = AREA_W'($urandom);
        r.phone = PHONE_W'($urandom);
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_beat(logic [2:0] act, int idx, t_rec r, logic [2:0] kind);
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        start       <= 1'b1;
        action      <= act;
        rec_index   <= idx[IDX_W-1:0];
        rec         <= r;
        filter_kind <= kind;
        do @(posedge i_clk); while (busy);
        sent++;
        @(negedge i_clk);
    endtask

    initial begin
        t_rec       r;
        t_rec       full_rec;
        logic [2:0] act;
        int         pick;
        int         idx;
        start       = 1'b0;
        action      = ACT_APPEND;
        rec_index   = '0;
        rec         = '0;
        filter_kind = FK_TOT_EQ;
        i_rst_n     = 1'b0;
        sent        = 0;
        gap_pct     = 37;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        full_rec = '1;
        send_beat(ACT_LOOKUP, 0, random_record(), FK_TOT_EQ);
        send_beat(ACT_FILTER, 0, random_record(), FK_DATE);
        send_beat(ACT_REPLACE, 0, full_rec, FK_TOT_EQ);
        send_beat(ACT_DELETE, 31, full_rec, FK_TOT_EQ);
        send_beat(3'd6, 7, full_rec, FK_TOT_EQ);
        send_beat(3'd7, 3, full_rec, FK_TOT_EQ);
        send_beat(ACT_DEDUPE, 0, full_rec, FK_TOT_EQ);
        send_beat(ACT_APPEND, 0, full_rec, FK_TOT_EQ);
        send_beat(ACT_APPEND, 0, '0, FK_TOT_EQ);
        r = random_record();
        r.id = 5;
        send_beat(ACT_APPEND, 0, r, FK_TOT_EQ);
        r.rooms = 8'd3;
        send_beat(ACT_APPEND, 0, r, FK_TOT_EQ);
        send_beat(ACT_LOOKUP, 0, full_rec, FK_TOT_EQ);
        send_beat(ACT_LOOKUP, 0, r, FK_TOT_EQ);
        for (int k = 0; k < 8; k++) send_beat(ACT_FILTER, 0, r, 3'(k));
        send_beat(ACT_REPLACE, 1, random_record(), FK_TOT_EQ);
        send_beat(ACT_DEDUPE, 0, '0, FK_TOT_EQ);
        send_beat(ACT_REPLACE, 30, r, FK_TOT_EQ);
        send_beat(ACT_DELETE, 0, '0, FK_TOT_EQ);

        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = (phase == 0) ? 37 : (phase == 1) ? 60 : 0;
            for (int n = 0; n < 152; n++) begin
                pick = $urandom_range(0, 99);
                // fill hard early in the phase, drain toward its end
                if (n < 50) pick = (pick < 75) ? 0 : pick;
                else if (n > 110) pick = (pick < 40) ? 40 : pick;
                if (pick < 35)      act = ACT_APPEND;
                else if (pick < 45) act = ACT_REPLACE;
                else if (pick < 62) act = ACT_DELETE;
                else if (pick < 67) act = ACT_DEDUPE;
                else if (pick < 81) act = ACT_LOOKUP;
                else if (pick < 96) act = ACT_FILTER;
                else                act = 3'($urandom_range(6, 7));
                idx = ($urandom_range(0, 3) == 0 || o_entry_count == 0) ?
                      $urandom_range(0, 31) : $urandom_range(0, o_entry_count - 1);
                send_beat(act, idx, random_record(), 3'($urandom_range(0, 7)));
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d commands, checked %0d result beats.", sent, results);
        if (failures == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/krt_pkg.sv
src/keyed_record_table.sv
sim/krt_checker.sv
sim/keyed_record_table_test.sv
